### rtl/fbt_pkg.sv
// Package with widths, register codes and state types for the flow bulk transfer tracker.
`timescale 1ns / 1ps
`default_nettype none

package fbt_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CntW    = 32;
  localparam int unsigned SumW    = 48;
  localparam int unsigned RunPktW = 16;
  localparam int unsigned RunByW  = 32;
  localparam int unsigned GapW    = 32;
  localparam int unsigned ThrW    = 8;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgGapTimeout   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBulkThreshold = 1'b1;

  localparam logic [GapW-1:0] GapTimeoutRst   = 32'd1000000;
  localparam logic [ThrW-1:0] BulkThresholdRst = 8'd4;

  // Candidate run of one direction
  typedef struct packed {
    logic               open;
    logic [TimeW-1:0]   start;
    logic [TimeW-1:0]   last;
    logic [RunPktW-1:0] packets;
    logic [RunByW-1:0]  bytes;
  } run_t;

  // Bulk totals of one direction
  typedef struct packed {
    logic [CntW-1:0] runs;
    logic [CntW-1:0] packets;
    logic [SumW-1:0] bytes;
    logic [SumW-1:0] time_us;
  } tot_t;

endpackage

`default_nettype wire

### rtl/fbt_if.sv
// Handshake interfaces for packet descriptors and bulk totals.
`timescale 1ns / 1ps
`default_nettype none

interface fbt_in_if;
  import fbt_pkg::*;
  logic             valid;
  logic             ready;
  logic [TimeW-1:0] timestamp_us;
  logic [LenW-1:0]  payload_len;
  logic             direction;

  modport source (output valid, timestamp_us, payload_len, direction, input ready);
  modport sink   (input valid, timestamp_us, payload_len, direction, output ready);
endinterface

interface fbt_out_if;
  import fbt_pkg::*;
  logic            valid;
  logic            ready;
  logic [CntW-1:0] fwd_bulk_runs;
  logic [CntW-1:0] fwd_bulk_packets;
  logic [SumW-1:0] fwd_bulk_bytes;
  logic [SumW-1:0] fwd_bulk_time_us;
  logic [CntW-1:0] rev_bulk_runs;
  logic [CntW-1:0] rev_bulk_packets;
  logic [SumW-1:0] rev_bulk_bytes;
  logic [SumW-1:0] rev_bulk_time_us;

  modport source (output valid, fwd_bulk_runs, fwd_bulk_packets, fwd_bulk_bytes,
                  fwd_bulk_time_us, rev_bulk_runs, rev_bulk_packets, rev_bulk_bytes,
                  rev_bulk_time_us, input ready);
  modport sink   (input valid, fwd_bulk_runs, fwd_bulk_packets, fwd_bulk_bytes,
                  fwd_bulk_time_us, rev_bulk_runs, rev_bulk_packets, rev_bulk_bytes,
                  rev_bulk_time_us, output ready);
endinterface

`default_nettype wire

### rtl/flow_bulk_transfer_tracker_unit.sv
// Top level of the flow bulk transfer tracker: per-direction bulk run detection and totals.
//
//   channel  | dir | handshake       | payload
//   ---------+-----+-----------------+------------------------------------------------
//   in_i     | in  | valid / ready   | timestamp_us[48] payload_len[16] direction[1]
//   out_o    | out | valid / ready   | fwd/rev bulk runs, packets, bytes, time_us
//   cfg      | in  | cfg_we_i        | cfg_idx_i[1] cfg_data_i[32], no read-back
//
// Input register then totals registers; one transaction per cycle unless the result stalls.
// The state update (compare, subtract, saturating add) runs between the input register
// and the totals registers, which also serve as the result register.
// Reset clears all run state and totals; config returns to 1000000 us and 4 packets.
// A stalled result holds the input register; in_i.ready stays high while it can drain.
`timescale 1ns / 1ps
`default_nettype none

module flow_bulk_transfer_tracker_unit
  import fbt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  fbt_in_if.sink                  in_i,
  fbt_out_if.source               out_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  logic [GapW-1:0] gap_timeout_q;
  logic [ThrW-1:0] threshold_q;

  logic             in_valid_q;
  logic [TimeW-1:0] ts_q;
  logic [LenW-1:0]  len_q;
  logic             dir_q;

  logic out_valid_q;

  run_t run_q [2];
  run_t run_d [2];
  tot_t tot_q [2];
  tot_t tot_d [2];

  logic advance, out_free;

  assign out_free    = !out_valid_q || out_o.ready;
  assign advance     = in_valid_q && out_free;
  assign in_i.ready  = !in_valid_q || out_free;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_timeout_q <= GapTimeoutRst;
      threshold_q   <= BulkThresholdRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGapTimeout:    gap_timeout_q <= cfg_data_i;
        CfgBulkThreshold: threshold_q   <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ts_q  <= in_i.timestamp_us;
      len_q <= in_i.payload_len;
      dir_q <= in_i.direction;
    end
  end

  // Update of the addressed direction
  run_t               cur, oth, cur_new;
  tot_t               tot_cur, tot_new;
  logic               closing, gap_over, start_new, hit, over;
  logic [TimeW-1:0]   gap, since_start;
  logic [RunPktW:0]   pk_sum;
  logic [RunPktW-1:0] pk_new;
  logic [RunByW:0]    by_sum;
  logic [RunByW-1:0]  by_new;
  logic [CntW:0]      runs_sum, pkts_sum;
  logic [SumW:0]      bytes_sum, time_sum;
  logic [CntW-1:0]    add_pk;
  logic [SumW-1:0]    add_by, add_tm;

  always_comb begin
    cur     = dir_q ? run_q[1] : run_q[0];
    oth     = dir_q ? run_q[0] : run_q[1];
    tot_cur = dir_q ? tot_q[1] : tot_q[0];

    closing     = cur.open && (oth.last > cur.start);
    gap         = (ts_q >= cur.last)  ? ts_q - cur.last  : '0;
    since_start = (ts_q >= cur.start) ? ts_q - cur.start : '0;
    gap_over    = gap > {{(TimeW-GapW){1'b0}}, gap_timeout_q};
    start_new   = !cur.open || closing || gap_over;

    pk_sum = {1'b0, cur.packets} + {{RunPktW{1'b0}}, 1'b1};
    pk_new = pk_sum[RunPktW] ? '1 : pk_sum[RunPktW-1:0];
    by_sum = {1'b0, cur.bytes} + {{(RunByW-LenW+1){1'b0}}, len_q};
    by_new = by_sum[RunByW] ? '1 : by_sum[RunByW-1:0];

    hit  = pk_new == {{(RunPktW-ThrW){1'b0}}, threshold_q};
    over = pk_new >  {{(RunPktW-ThrW){1'b0}}, threshold_q};

    add_pk = hit ? {{(CntW-RunPktW){1'b0}}, pk_new} : {{(CntW-1){1'b0}}, 1'b1};
    add_by = hit ? {{(SumW-RunByW){1'b0}}, by_new} : {{(SumW-LenW){1'b0}}, len_q};
    add_tm = hit ? since_start : gap;

    runs_sum  = {1'b0, tot_cur.runs} + {{CntW{1'b0}}, 1'b1};
    pkts_sum  = {1'b0, tot_cur.packets} + {1'b0, add_pk};
    bytes_sum = {1'b0, tot_cur.bytes} + {1'b0, add_by};
    time_sum  = {1'b0, tot_cur.time_us} + {1'b0, add_tm};

    cur_new = cur;
    tot_new = tot_cur;
    if (len_q != '0) begin
      if (start_new) begin
        cur_new.open    = 1'b1;
        cur_new.start   = ts_q;
        cur_new.last    = ts_q;
        cur_new.packets = {{(RunPktW-1){1'b0}}, 1'b1};
        cur_new.bytes   = {{(RunByW-LenW){1'b0}}, len_q};
      end else begin
        cur_new.packets = pk_new;
        cur_new.bytes   = by_new;
        cur_new.last    = ts_q;
        if (hit) begin
          tot_new.runs = runs_sum[CntW] ? '1 : runs_sum[CntW-1:0];
        end
        if (hit || over) begin
          tot_new.packets = pkts_sum[CntW]  ? '1 : pkts_sum[CntW-1:0];
          tot_new.bytes   = bytes_sum[SumW] ? '1 : bytes_sum[SumW-1:0];
          tot_new.time_us = time_sum[SumW]  ? '1 : time_sum[SumW-1:0];
        end
      end
    end

    run_d[0] = dir_q ? run_q[0] : cur_new;
    run_d[1] = dir_q ? cur_new  : run_q[1];
    tot_d[0] = dir_q ? tot_q[0] : tot_new;
    tot_d[1] = dir_q ? tot_new  : tot_q[1];
  end

  // State and totals advance only with a transaction into the result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q[0] <= '0;
      run_q[1] <= '0;
      tot_q[0] <= '0;
      tot_q[1] <= '0;
    end else if (advance) begin
      run_q[0] <= run_d[0];
      run_q[1] <= run_d[1];
      tot_q[0] <= tot_d[0];
      tot_q[1] <= tot_d[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Totals registers hold still while a result waits, so they drive the payload directly
  assign out_o.valid            = out_valid_q;
  assign out_o.fwd_bulk_runs    = tot_q[0].runs;
  assign out_o.fwd_bulk_packets = tot_q[0].packets;
  assign out_o.fwd_bulk_bytes   = tot_q[0].bytes;
  assign out_o.fwd_bulk_time_us = tot_q[0].time_us;
  assign out_o.rev_bulk_runs    = tot_q[1].runs;
  assign out_o.rev_bulk_packets = tot_q[1].packets;
  assign out_o.rev_bulk_bytes   = tot_q[1].bytes;
  assign out_o.rev_bulk_time_us = tot_q[1].time_us;

endmodule

`default_nettype wire

### rtl/fbt_checker.sv
// Port-level checker for the flow bulk transfer tracker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fbt_checker
  import fbt_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire logic [CntW-1:0] fwd_runs,
  input wire logic [CntW-1:0] fwd_packets,
  input wire logic [CntW-1:0] rev_runs,
  input wire logic [CntW-1:0] rev_packets
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A fresh result follows an input transaction taken through the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without input transaction");

  // Bulk packet totals only grow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> fwd_packets >= $past(fwd_packets) && rev_packets >= $past(rev_packets))
    else $error("bulk packet total decreased");

  // Every counted run brings at least one packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_runs <= fwd_packets && rev_runs <= rev_packets)
    else $error("more bulk runs than bulk packets");

endmodule

bind flow_bulk_transfer_tracker_unit fbt_checker u_fbt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .fwd_runs    (out_o.fwd_bulk_runs),
  .fwd_packets (out_o.fwd_bulk_packets),
  .rev_runs    (out_o.rev_bulk_runs),
  .rev_packets (out_o.rev_bulk_packets)
);

`default_nettype wire

### tb/bulk_totals_checker.sv
// Checker for the bulk transfer tracker: predicts both directions' totals and compares results.
`timescale 1ns / 1ps

module bulk_totals_checker
  import fbt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  fbt_in_if                  pkt_i,
  fbt_out_if                 tot_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam logic [63:0] Max16 = 64'hFFFF;
  localparam logic [63:0] Max32 = 64'hFFFF_FFFF;
  localparam logic [63:0] Max48 = 64'hFFFF_FFFF_FFFF;

  typedef struct packed {
    tot_t fwd;
    tot_t rev;
  } totals_pair_t;

  run_t            run_st [2];
  tot_t            tot_st [2];
  logic [GapW-1:0] gap_cfg;
  logic [ThrW-1:0] thr_cfg;
  totals_pair_t    expected_totals [$];

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    if (a >= lim || b >= lim - a) return lim;
    return a + b;
  endfunction

  // Negative differences count as zero
  function automatic logic [TimeW-1:0] elapsed(logic [TimeW-1:0] later,
                                               logic [TimeW-1:0] earlier);
    return (later >= earlier) ? later - earlier : '0;
  endfunction

  task automatic advance_bulk_state(input logic [TimeW-1:0] ts, input logic [LenW-1:0] len,
                                    input logic dir);
    int d;
    int o;
    d = int'(dir);
    o = 1 - d;
    if (len != '0) begin
      // Close the run once the other direction has spoken since it started
      if (run_st[d].open && run_st[o].last > run_st[d].start) run_st[d].open = 1'b0;
      if (!run_st[d].open || elapsed(ts, run_st[d].last) > gap_cfg) begin
        run_st[d].open    = 1'b1;
        run_st[d].start   = ts;
        run_st[d].last    = ts;
        run_st[d].packets = RunPktW'(1);
        run_st[d].bytes   = RunByW'(len);
      end else begin
        run_st[d].packets = RunPktW'(sat_sum(64'(run_st[d].packets), 64'd1, Max16));
        run_st[d].bytes   = RunByW'(sat_sum(64'(run_st[d].bytes), 64'(len), Max32));
        if (run_st[d].packets == RunPktW'(thr_cfg)) begin
          tot_st[d].runs    = CntW'(sat_sum(64'(tot_st[d].runs), 64'd1, Max32));
          tot_st[d].packets = CntW'(sat_sum(64'(tot_st[d].packets),
                                            64'(run_st[d].packets), Max32));
          tot_st[d].bytes   = SumW'(sat_sum(64'(tot_st[d].bytes),
                                            64'(run_st[d].bytes), Max48));
          tot_st[d].time_us = SumW'(sat_sum(64'(tot_st[d].time_us),
                                            64'(elapsed(ts, run_st[d].start)), Max48));
        end else if (run_st[d].packets > RunPktW'(thr_cfg)) begin
          tot_st[d].packets = CntW'(sat_sum(64'(tot_st[d].packets), 64'd1, Max32));
          tot_st[d].bytes   = SumW'(sat_sum(64'(tot_st[d].bytes), 64'(len), Max48));
          tot_st[d].time_us = SumW'(sat_sum(64'(tot_st[d].time_us),
                                            64'(elapsed(ts, run_st[d].last)), Max48));
        end
        run_st[d].last = ts;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      fail_count_o = fail_count_o + 1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    totals_pair_t want;
    if (!rst_ni) begin
      for (int d = 0; d < 2; d++) begin
        run_st[d] = '0;
        tot_st[d] = '0;
      end
      gap_cfg = GapTimeoutRst;
      thr_cfg = BulkThresholdRst;
      expected_totals.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgGapTimeout:    gap_cfg = cfg_data_i[GapW-1:0];
          CfgBulkThreshold: thr_cfg = cfg_data_i[ThrW-1:0];
          default: ;
        endcase
      end
      if (pkt_i.valid && pkt_i.ready) begin
        advance_bulk_state(pkt_i.timestamp_us, pkt_i.payload_len, pkt_i.direction);
        expected_totals.push_back(totals_pair_t'{fwd: tot_st[0], rev: tot_st[1]});
      end
      if (tot_i.valid && tot_i.ready) begin
        if (expected_totals.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          $display("%0t: result transaction with no packet pending, expected none, actual %0d",
                   $time, tot_i.fwd_bulk_runs);
        end else begin
          want = expected_totals.pop_front();
          check_field("fwd_bulk_runs",    64'(want.fwd.runs),    64'(tot_i.fwd_bulk_runs));
          check_field("fwd_bulk_packets", 64'(want.fwd.packets), 64'(tot_i.fwd_bulk_packets));
          check_field("fwd_bulk_bytes",   64'(want.fwd.bytes),   64'(tot_i.fwd_bulk_bytes));
          check_field("fwd_bulk_time_us", 64'(want.fwd.time_us), 64'(tot_i.fwd_bulk_time_us));
          check_field("rev_bulk_runs",    64'(want.rev.runs),    64'(tot_i.rev_bulk_runs));
          check_field("rev_bulk_packets", 64'(want.rev.packets), 64'(tot_i.rev_bulk_packets));
          check_field("rev_bulk_bytes",   64'(want.rev.bytes),   64'(tot_i.rev_bulk_bytes));
          check_field("rev_bulk_time_us", 64'(want.rev.time_us), 64'(tot_i.rev_bulk_time_us));
        end
      end
    end
    pending_o = expected_totals.size();
  end

endmodule

### tb/testbench.sv
// Top of the bulk transfer tracker testbench: packet stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module testbench;
  import fbt_pkg::*;

  localparam int CycleLimit = 1000000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;
  bit                 idle_en;
  int                 fail_count;
  int                 pending;
  int                 cycle_count = 0;
  logic [TimeW-1:0]   cur_ts;
  logic [GapW-1:0]    cur_gap;
  logic [ThrW-1:0]    cur_thr;

  fbt_in_if  pkt_bus ();
  fbt_out_if tot_bus ();

  flow_bulk_transfer_tracker_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (pkt_bus),
    .out_o      (tot_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  bulk_totals_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pkt_i        (pkt_bus),
    .tot_i        (tot_bus),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    tot_bus.ready <= idle_en ? ($urandom_range(99) >= 38) : 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** flow_bulk_transfer_tracker_unit: FAILED **");
      $finish;
    end
  end

  // Tidy steps mostly stay within the gap so runs can reach the threshold
  function automatic logic [TimeW-1:0] next_stamp(input bit tidy);
    int          r;
    logic [63:0] step;
    r = $urandom_range(99);
    if (tidy) r = (r < 2) ? 80 : r % 72;
    if (r < 60)      step = (cur_gap == '0) ? 64'd0 : 64'($urandom_range(cur_gap, 0));
    else if (r < 72) step = 64'(cur_gap);
    else if (r < 84) step = 64'(cur_gap) + 64'd1 + 64'($urandom_range(5000));
    else if (r < 94) step = 64'd0;
    else return cur_ts - TimeW'($urandom_range(2000, 1));
    return cur_ts + step[TimeW-1:0];
  endfunction

  function automatic logic [LenW-1:0] random_len();
    int r;
    r = $urandom_range(99);
    if (r < 4)  return '0;
    if (r < 8)  return '1;
    if (r < 12) return LenW'(1);
    return LenW'($urandom_range(65535, 1));
  endfunction

  task automatic send_packet(input logic [TimeW-1:0] ts, input logic [LenW-1:0] len,
                             input logic dir);
    if (idle_en && $urandom_range(99) < 38) begin
      pkt_bus.valid <= 1'b0;
      do @(posedge clk_i); while (idle_en && $urandom_range(99) < 38);
    end
    pkt_bus.valid        <= 1'b1;
    pkt_bus.timestamp_us <= ts;
    pkt_bus.payload_len  <= len;
    pkt_bus.direction    <= dir;
    do @(posedge clk_i); while (!pkt_bus.ready);
  endtask

  // Drop valid and wait for every pending result, then let the pipeline empty
  task automatic settle();
    pkt_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [GapW-1:0] gap, input logic [ThrW-1:0] thr);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgGapTimeout;
    cfg_data <= CfgW'(gap);
    @(posedge clk_i);
    cfg_idx  <= CfgBulkThreshold;
    // upper bits are junk; only the low byte is the threshold
    cfg_data <= ($urandom() & 32'hFFFF_FF00) | CfgW'(thr);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cur_gap  = gap;
    cur_thr  = thr;
  endtask

  task automatic random_phase(input int n_items);
    int               count;
    int               blen;
    int               lo;
    logic             dir;
    logic [LenW-1:0]  len;
    count = 0;
    cur_ts = TimeW'({$urandom(), $urandom()});
    while (count < n_items) begin
      if ($urandom_range(99) < 15) begin
        // noise: any direction, any step
        cur_ts = next_stamp(1'b0);
        len = random_len();
        send_packet(cur_ts, len, 1'($urandom_range(1)));
        if (len != '0) count++;
      end else begin
        dir = 1'($urandom_range(1));
        lo = (cur_thr > 1) ? int'(cur_thr) - 1 : 1;
        blen = $urandom_range(1) ? $urandom_range(int'(cur_thr) + 4, lo)
                                 : $urandom_range(int'(cur_thr) + 4, 1);
        repeat (blen) begin
          cur_ts = next_stamp(1'b1);
          len = random_len();
          send_packet(cur_ts, len, dir);
          if (len != '0) count++;
        end
      end
    end
  endtask

  initial begin
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= CfgGapTimeout;
    cfg_data             <= '0;
    pkt_bus.valid        <= 1'b0;
    pkt_bus.timestamp_us <= '0;
    pkt_bus.payload_len  <= '0;
    pkt_bus.direction    <= 1'b0;
    idle_en = 1'b1;
    cur_ts  = '0;
    cur_gap = GapTimeoutRst;
    cur_thr = BulkThresholdRst;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed packets under the reset settings
    send_packet(48'd0, 16'd0, 1'b0);                      // zero payload
    send_packet(48'd10, 16'd1, 1'b0);
    send_packet(48'd20, 16'hFFFF, 1'b0);
    send_packet(48'd30, 16'd100, 1'b0);
    send_packet(48'd40, 16'd7, 1'b0);                     // reaches the threshold
    send_packet(48'd1000, 16'd9, 1'b0);                   // extends the bulk run
    send_packet(48'd1000, 16'd0, 1'b1);
    send_packet(48'd1001, 16'd5, 1'b1);
    send_packet(48'd1002, 16'd3, 1'b0);                   // closed by the reverse packet
    send_packet(48'd1001002, 16'd4, 1'b0);                // gap exactly at the timeout
    send_packet(48'd2001003, 16'd4, 1'b0);                // gap just past the timeout
    send_packet(48'd2000503, 16'd6, 1'b0);                // time going backwards
    send_packet(48'd2000503, 16'd8, 1'b0);
    send_packet(48'd2000503, 16'd8, 1'b0);
    send_packet(48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
    send_packet(48'hFFFF_FFFF_FFFF, 16'hFFFF, 1'b1);
    send_packet(48'hFFFF_FFFF_FFFF, 16'd1, 1'b1);
    send_packet(48'hFFFF_FFFF_FFFF, 16'd2, 1'b1);
    send_packet(48'd0, 16'hFFFF, 1'b1);
    send_packet(48'd0, 16'd1, 1'b0);

    random_phase(250);
    set_config(32'd0, 8'd2);
    random_phase(150);
    set_config(32'hFFFF_FFFF, 8'd255);
    random_phase(450);
    set_config(32'd50, 8'd1);                             // threshold below two
    random_phase(120);
    set_config(32'd200, 8'd0);
    random_phase(120);
    idle_en = 1'b0;
    set_config(32'($urandom_range(100000, 1)), 8'($urandom_range(12, 2)));
    random_phase(250);
    idle_en = 1'b1;
    set_config(GapTimeoutRst, BulkThresholdRst);
    random_phase(100);

    settle();
    repeat (6) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** flow_bulk_transfer_tracker_unit: PASSED **");
    end else begin
      $display("** flow_bulk_transfer_tracker_unit: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fbt_pkg.sv
rtl/fbt_if.sv
rtl/flow_bulk_transfer_tracker_unit.sv
rtl/fbt_checker.sv
tb/bulk_totals_checker.sv
tb/testbench.sv
